### hw/rtl/bdq_pkg.sv
// Shared constants, operation codes and cell control types for the bounded deque.
package bdq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FUNC_W     = 3;
	localparam int CAP_W      = 5;
	localparam int INDEX_W    = 4;
	localparam int OUT_DATA_W = 32;

	localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_READ       = 3'd4;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef logic [DATA_WIDTH-1:0] data_t;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_SHR  = 2'd1,
		CELL_SHL  = 2'd2,
		CELL_LOAD = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
	} cell_ctl_t;

endpackage

### hw/rtl/bdq_cell.sv
// One storage cell of the deque chain: holds, shifts from a neighbour or loads a new record.
module bdq_cell (
	input  logic              clk,
	input  bdq_pkg::cell_ctl_t ctl,
	input  bdq_pkg::data_t    left_data,
	input  bdq_pkg::data_t    right_data,
	input  bdq_pkg::data_t    load_data,
	output bdq_pkg::data_t    data_q
);
	import bdq_pkg::*;

	// Payload only, so the cell needs no reset.
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_SHR:  data_q <= left_data;
			CELL_SHL:  data_q <= right_data;
			CELL_LOAD: data_q <= load_data;
			default:   data_q <= data_q;
		endcase
	end

endmodule

### hw/rtl/bounded_deque_with_eviction_core.sv
// Top level of the bounded double-ended queue with eviction, built as a chain of cells.
//
// Usage: an item enters on the input channel (in_valid / in_ready) carrying func, data_in and
// index. Each item produces exactly one result item on the output channel (out_valid /
// out_ready) with read_data, found, evicted and occupancy. Pushes at the front or back evict
// one element from the opposite end when the queue is at or above its capacity; pops and reads
// that find nothing return zero with found cleared.
// The records live in a row of identical cells, cell 0 being the front. A push at the front or
// a pop from the front shifts the whole chain by one place; a push at the back
// loads one cell, or, when it evicts, shifts the chain towards the front and loads the last
// occupied cell. A read or pop from the back selects one cell through a 16-way multiplexer.
// The output register after the chain update holds the result, and the block takes one item
// per cycle while the receiver keeps up; it is the only register on the path.
// The input is accepted while the output register is empty or is being emptied in that cycle,
// so a stalled receiver holds the result and stops further items, and nothing is lost.
// Capacity is written through cfg_we / cfg_wdata and takes effect from the next item; values
// above the chain length behave as the chain length.
// Reset (arst_n low) empties the queue, clears the output valid and sets capacity to 16.
// Cell contents are not reset: only cells that have been written are ever read.
module bounded_deque_with_eviction_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [bdq_pkg::FUNC_W-1:0]     func,
	input  logic [bdq_pkg::DATA_WIDTH-1:0] data_in,
	input  logic [bdq_pkg::INDEX_W-1:0]    index,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bdq_pkg::OUT_DATA_W-1:0] read_data,
	output logic                           found,
	output logic                           evicted,
	output logic [bdq_pkg::CNT_W-1:0]      occupancy,
	input  logic                           cfg_we,
	input  logic [bdq_pkg::CAP_W-1:0]      cfg_wdata
);
	import bdq_pkg::*;

	logic [CAP_W-1:0]  capacity_q;
	logic [CNT_W-1:0]  count_q;
	logic              out_valid_q;
	data_t             read_data_q;
	logic              found_q;
	logic              evicted_q;
	logic [CNT_W-1:0]  occupancy_q;

	logic              in_fire;
	logic [CNT_W-1:0]  eff_cap;
	logic              full_evict;
	logic [CNT_W-1:0]  cnt_m1;
	logic [IDX_W-1:0]  rd_addr;
	data_t             rd_cell;
	logic              is_push;
	logic              evict_now;
	logic              found_now;
	logic [CNT_W-1:0]  count_next;
	data_t             rd_now;

	data_t             cell_data [DEPTH];
	cell_ctl_t         cell_ctl  [DEPTH];

	assign in_fire = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;

	// The effective capacity never exceeds the number of cells.
	assign eff_cap = (CNT_W'(capacity_q) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(capacity_q);
	assign full_evict = (count_q != '0) && (count_q >= eff_cap);
	assign cnt_m1 = count_q - CNT_W'(1);

	// One read port over the chain: front for pop front, last element for pop back,
	// the requested position for a read.
	always_comb begin
		rd_addr = '0;
		if (func == FN_POP_BACK) begin
			rd_addr = cnt_m1[IDX_W-1:0];
		end else if (func == FN_READ) begin
			rd_addr = IDX_W'(index);
		end
	end
	assign rd_cell = cell_data[rd_addr];

	always_comb begin
		is_push    = 1'b0;
		evict_now  = 1'b0;
		found_now  = 1'b0;
		count_next = count_q;
		unique case (func)
			FN_PUSH_FRONT, FN_PUSH_BACK: begin
				is_push   = 1'b1;
				evict_now = full_evict;
				if (!full_evict) begin
					count_next = count_q + CNT_W'(1);
				end
			end
			FN_POP_FRONT, FN_POP_BACK: begin
				if (count_q != '0) begin
					found_now  = 1'b1;
					count_next = cnt_m1;
				end
			end
			FN_READ: begin
				found_now = ({{(CNT_W - INDEX_W){1'b0}}, index} < count_q);
			end
			default: begin
				found_now = 1'b0;
			end
		endcase
	end

	assign rd_now = found_now ? rd_cell : '0;

	// Per-cell control: every cell is told what to do in this cycle.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_ctl[i].op = CELL_HOLD;
			if (in_fire) begin
				if (func == FN_PUSH_FRONT) begin
					cell_ctl[i].op = CELL_SHR;
				end else if (func == FN_POP_FRONT && count_q != '0) begin
					cell_ctl[i].op = CELL_SHL;
				end else if (func == FN_PUSH_BACK) begin
					if (full_evict) begin
						cell_ctl[i].op = (cnt_m1 == CNT_W'(i)) ? CELL_LOAD : CELL_SHL;
					end else if (count_q == CNT_W'(i)) begin
						cell_ctl[i].op = CELL_LOAD;
					end
				end
			end
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		data_t left_d;
		data_t right_d;
		if (g == 0) begin : g_first
			assign left_d = data_in;
		end else begin : g_mid
			assign left_d = cell_data[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_inner
			assign right_d = cell_data[g+1];
		end
		bdq_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[g]),
			.left_data  (left_d),
			.right_data (right_d),
			.load_data  (data_in),
			.data_q     (cell_data[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAP_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (in_fire) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			read_data_q <= rd_now;
			found_q     <= found_now && !is_push;
			evicted_q   <= evict_now;
			occupancy_q <= count_next;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = OUT_DATA_W'(read_data_q);
	assign found     = found_q;
	assign evicted   = evicted_q;
	assign occupancy = occupancy_q;

	// The count never exceeds the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("element count above chain length");

	// A result never reports both a found record and an eviction.
	a_found_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(found_q && evicted_q))
		else $error("found and evicted both set");

	// After an accepted push the queue is never empty.
	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (func == FN_PUSH_FRONT || func == FN_PUSH_BACK)) |=> count_q != '0)
		else $error("queue empty after push");

	// A pop from an empty queue reports nothing found and zero data.
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && count_q == '0 && (func == FN_POP_FRONT || func == FN_POP_BACK))
		|=> (!found_q && read_data_q == '0))
		else $error("pop from empty queue returned data");

endmodule

### dv/tb_bounded_deque_with_eviction_core.sv
// Self-checking testbench for the bounded double-ended queue with eviction.
`timescale 1ns / 1ps

module tb_bounded_deque_with_eviction_core;
	import bdq_pkg::*;

	// Function codes above the read code do nothing but report the occupancy.
	localparam logic [FUNC_W-1:0] FN_UNUSED_LO  = 3'd5;
	localparam logic [FUNC_W-1:0] FN_UNUSED_MID = 3'd6;
	localparam logic [FUNC_W-1:0] FN_UNUSED_HI  = 3'd7;

	// The receiver's long hold-off, and the most cycles without any item moving.
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct {
		logic [OUT_DATA_W-1:0] read_data;
		logic                  found;
		logic                  evicted;
		logic [CNT_W-1:0]      occupancy;
	} deque_result_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [FUNC_W-1:0]     func      = FN_PUSH_FRONT;
	logic [DATA_WIDTH-1:0] data_in   = '0;
	logic [INDEX_W-1:0]    index     = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [OUT_DATA_W-1:0] read_data;
	logic                  found;
	logic                  evicted;
	logic [CNT_W-1:0]      occupancy;
	logic                  cfg_we    = 1'b0;
	logic [CAP_W-1:0]      cfg_wdata = '0;

	// Our own picture of the queue: a ring, its front position, its fill and the capacity.
	data_t            shadow_ring [DEPTH];
	int unsigned      shadow_head  = 0;
	int unsigned      shadow_count = 0;
	logic [CAP_W-1:0] shadow_cap   = CAP_RESET;

	// Results still owed by the block, oldest first.
	deque_result_t pending_results [$];

	int  mismatches   = 0;
	int  idle_cycles  = 0;
	bit  sender_gaps  = 1'b0;
	bit  recv_stalls  = 1'b0;
	bit  hold_pending = 1'b0;

	bounded_deque_with_eviction_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.data_in   (data_in),
		.index     (index),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.read_data (read_data),
		.found     (found),
		.evicted   (evicted),
		.occupancy (occupancy),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// Applies one operation to the shadow queue and returns the result it should produce.
	// A push into a queue at or above the effective capacity first drops one element from
	// the far end, so a lowered capacity never makes a single push shed more than one.
	function automatic deque_result_t deque_predict(input logic [FUNC_W-1:0] op,
			input data_t rec, input logic [INDEX_W-1:0] pos);
		deque_result_t res;
		int unsigned   eff_cap;
		res.read_data = '0;
		res.found     = 1'b0;
		res.evicted   = 1'b0;
		eff_cap = (shadow_cap < DEPTH) ? shadow_cap : DEPTH;
		unique case (op)
			FN_PUSH_FRONT, FN_PUSH_BACK: begin
				if (shadow_count > 0 && shadow_count >= eff_cap) begin
					res.evicted = 1'b1;
					// Pushing at the front loses the back element, and vice versa.
					if (op == FN_PUSH_BACK)
						shadow_head = (shadow_head + 1) % DEPTH;
					shadow_count--;
				end
				if (op == FN_PUSH_FRONT) begin
					shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
					shadow_ring[shadow_head] = rec;
				end else begin
					shadow_ring[(shadow_head + shadow_count) % DEPTH] = rec;
				end
				shadow_count++;
			end
			FN_POP_FRONT: begin
				if (shadow_count > 0) begin
					res.read_data = shadow_ring[shadow_head];
					res.found     = 1'b1;
					shadow_head   = (shadow_head + 1) % DEPTH;
					shadow_count--;
				end
			end
			FN_POP_BACK: begin
				if (shadow_count > 0) begin
					res.read_data = shadow_ring[(shadow_head + shadow_count - 1) % DEPTH];
					res.found     = 1'b1;
					shadow_count--;
				end
			end
			FN_READ: begin
				if (pos < shadow_count) begin
					res.read_data = shadow_ring[(shadow_head + pos) % DEPTH];
					res.found     = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res.occupancy = shadow_count[CNT_W-1:0];
		return res;
	endfunction

	// Offers one item, possibly after a random gap, and records what it should return once
	// the block has taken it. Valid is only lowered during a gap, so back-to-back items keep
	// it high without a glitch.
	task automatic send_op(input logic [FUNC_W-1:0] op, input data_t rec,
			input logic [INDEX_W-1:0] pos);
		int unsigned gap;
		if (sender_gaps && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= op;
		data_in  <= rec;
		index    <= pos;
		do @(posedge clk); while (!in_ready);
		pending_results = {pending_results, deque_predict(op, rec, pos)};
	endtask

	// Picks an operation with a given leaning towards pushes. Most reads aim inside the
	// queue so that stored records are actually seen; a few use any index or an unused code.
	task automatic send_random(input int unsigned push_pct);
		int unsigned      pick;
		logic [FUNC_W-1:0] op;
		logic [INDEX_W-1:0] pos;
		pick = $urandom_range(0, 99);
		pos  = INDEX_W'($urandom_range(0, DEPTH - 1));
		if (pick < 3) begin
			op = FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
		end else if (pick < 23) begin
			op = FN_READ;
			if (shadow_count > 0 && $urandom_range(0, 3) != 0)
				pos = INDEX_W'($urandom_range(0, shadow_count - 1));
		end else if ($urandom_range(0, 99) < push_pct) begin
			op = $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
		end else begin
			op = $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
		end
		send_op(op, $urandom, pos);
	endtask

	// Stops offering items and waits until every result has come back, plus a little slack
	// for the single output register.
	task automatic wait_for_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// The capacity register is only written with nothing in flight.
	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		wait_for_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we     <= 1'b0;
		shadow_cap = cap;
	endtask

	// Empty-queue pops and reads, the unused codes, extreme records and an out-of-range read.
	task automatic test_directed();
		sender_gaps = 1'b0;
		recv_stalls = 1'b0;
		send_op(FN_POP_FRONT, 32'h1234_5678, '0);
		send_op(FN_POP_BACK, 32'h8765_4321, '1);
		send_op(FN_READ, '0, '0);
		send_op(FN_READ, '1, '1);
		send_op(FN_UNUSED_LO, 32'hDEAD_BEEF, 4'h3);
		send_op(FN_UNUSED_MID, 32'hFFFF_FFFF, '1);
		send_op(FN_UNUSED_HI, 32'h0000_0001, '0);
		send_op(FN_PUSH_BACK, 32'h0000_0000, '1);
		send_op(FN_PUSH_FRONT, 32'hFFFF_FFFF, '0);
		send_op(FN_PUSH_BACK, 32'hA5A5_A5A5, 4'h9);
		send_op(FN_PUSH_FRONT, 32'h5A5A_5A5A, 4'h6);
		send_op(FN_READ, '0, 4'h0);
		send_op(FN_READ, '0, 4'h3);
		send_op(FN_READ, '0, 4'h4);
		send_op(FN_READ, '0, '1);
		send_op(FN_POP_BACK, '0, '0);
		send_op(FN_POP_FRONT, '0, '0);
		send_op(FN_POP_BACK, '0, '0);
		send_op(FN_POP_FRONT, '0, '0);
		send_op(FN_POP_FRONT, '0, '0);
		send_op(FN_PUSH_FRONT, 32'h8000_0000, '0);
		send_op(FN_READ, '0, '0);
		send_op(FN_POP_BACK, '0, '0);
	endtask

	// Random traffic under a spread of capacities: the extremes one and sixteen, zero, values
	// past the store size, and a few in between. Each setting runs in bursts whose items lean
	// towards filling, draining or neither, with idling switched on or off per burst.
	task automatic test_capacity_sweep();
		logic [CAP_W-1:0] cap_plan [8];
		int unsigned      lean [3];
		cap_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd8, 5'd5};
		lean     = '{80, 20, 50};
		foreach (cap_plan[c]) begin
			set_capacity(cap_plan[c]);
			for (int burst = 0; burst < 5; burst++) begin
				sender_gaps = ($urandom_range(0, 2) != 0);
				recv_stalls = ($urandom_range(0, 2) != 0);
				for (int n = 0; n < 32; n++)
					send_random(lean[$urandom_range(0, 2)]);
			end
		end
	endtask

	// Fills the queue, then lowers the capacity beneath the fill: every push must evict
	// exactly one element and leave the occupancy where it was.
	task automatic test_capacity_below_occupancy();
		set_capacity(5'd16);
		sender_gaps = 1'b1;
		recv_stalls = 1'b1;
		while (shadow_count < DEPTH)
			send_op(FN_PUSH_BACK, $urandom, '0);
		set_capacity(5'd3);
		for (int n = 0; n < 8; n++)
			send_op((n % 2) ? FN_PUSH_BACK : FN_PUSH_FRONT, $urandom, '0);
		for (int n = 0; n < 6; n++)
			send_op(FN_READ, '0, INDEX_W'($urandom_range(0, DEPTH - 1)));
		for (int n = 0; n < 16; n++)
			send_random(40);
	endtask

	// The receiver holds off for a long stretch while items keep coming, so the block must
	// stall its input and then release everything in order.
	task automatic test_backpressure();
		set_capacity(5'd16);
		sender_gaps  = 1'b0;
		recv_stalls  = 1'b0;
		hold_pending = 1'b1;
		for (int n = 0; n < 40; n++)
			send_random(60);
	endtask

	// The closing stretch runs at full rate on both sides.
	task automatic test_full_rate_tail();
		set_capacity(5'd16);
		sender_gaps = 1'b0;
		recv_stalls = 1'b0;
		for (int n = 0; n < 150; n++)
			send_random((n < 75) ? 70 : 30);
	endtask

	// Receiver: random stalls, plus one long hold-off when asked, counted here.
	initial begin : receiver
		int unsigned stall;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				out_ready <= 1'b0;
				for (int n = 0; n < LONG_HOLD; n++) @(posedge clk);
			end else if (recv_stalls && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 19);
				out_ready <= 1'b0;
				repeat (stall - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Each result the block hands over is matched with the oldest one still owed.
	always @(posedge clk) begin
		deque_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result item with none expected: read_data %h found %b occupancy %0d",
					read_data, found, occupancy);
				mismatches++;
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				if (read_data !== want.read_data) begin
					$error("read_data: expected %h, actual %h", want.read_data, read_data);
					mismatches++;
				end
				if (found !== want.found) begin
					$error("found: expected %b, actual %b", want.found, found);
					mismatches++;
				end
				if (evicted !== want.evicted) begin
					$error("evicted: expected %b, actual %b", want.evicted, evicted);
					mismatches++;
				end
				if (occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, actual %0d", want.occupancy, occupancy);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: ends the run if no item moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		foreach (shadow_ring[i])
			shadow_ring[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_capacity_sweep();
		test_capacity_below_occupancy();
		test_backpressure();
		test_full_rate_tail();
		wait_for_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
